// File: hdl/uxe_pkg.sv
// Shared types, constants and lookup functions for the UTF-8 aware XML escaper.
`timescale 1ns / 1ps
package uxe_pkg;

	localparam int BYTE_W        = 8;
	localparam int HELD_DEPTH    = 5;
	localparam int CNT_W         = 3;
	localparam int JOB_DEPTH_DEF = 2;

	// Characters that need an entity
	localparam logic [BYTE_W-1:0] CH_AMP  = 8'h26;
	localparam logic [BYTE_W-1:0] CH_LT   = 8'h3C;
	localparam logic [BYTE_W-1:0] CH_GT   = 8'h3E;
	localparam logic [BYTE_W-1:0] CH_APOS = 8'h27;
	localparam logic [BYTE_W-1:0] CH_QUOT = 8'h22;

	typedef enum logic [1:0] {
		JOB_BYTE,
		JOB_ENT,
		JOB_FLUSH,
		JOB_TRUNC
	} job_kind_t;

	typedef enum logic [2:0] {
		ENT_AMP,
		ENT_LT,
		ENT_GT,
		ENT_APOS,
		ENT_QUOT
	} ent_code_t;

	// One classified request handed from the front to the back
	typedef struct packed {
		job_kind_t                           kind;
		ent_code_t                           ent;
		logic [BYTE_W-1:0]                   data;
		logic [CNT_W-1:0]                    held_n;
		logic [HELD_DEPTH-1:0][BYTE_W-1:0]   held;
		logic                                last;
	} job_t;

	// Character length announced by a lead byte
	function automatic logic [CNT_W-1:0] lead_length(input logic [BYTE_W-1:0] b);
		logic [CNT_W-1:0] len;
		if (b inside {[8'hC0:8'hDF]}) begin
			len = 3'd2;
		end else if (b inside {[8'hE0:8'hEF]}) begin
			len = 3'd3;
		end else if (b inside {[8'hF0:8'hF7]}) begin
			len = 3'd4;
		end else if (b inside {[8'hF8:8'hFB]}) begin
			len = 3'd5;
		end else if (b inside {[8'hFC:8'hFD]}) begin
			len = 3'd6;
		end else begin
			len = 3'd1;
		end
		return len;
	endfunction

	// Number of bytes in an entity
	function automatic logic [CNT_W-1:0] ent_len(input ent_code_t code);
		logic [CNT_W-1:0] len;
		case (code)
			ENT_AMP:  len = 3'd5;
			ENT_LT:   len = 3'd4;
			ENT_GT:   len = 3'd4;
			ENT_APOS: len = 3'd6;
			ENT_QUOT: len = 3'd6;
			default:  len = 3'd1;
		endcase
		return len;
	endfunction

	// Byte idx of an entity text
	function automatic logic [BYTE_W-1:0] ent_char(input ent_code_t code,
		input logic [CNT_W-1:0] idx);
		logic [BYTE_W-1:0] c;
		c = ";";
		case (code)
			ENT_AMP: begin
				case (idx)
					3'd0:    c = "&";
					3'd1:    c = "a";
					3'd2:    c = "m";
					3'd3:    c = "p";
					default: c = ";";
				endcase
			end
			ENT_LT: begin
				case (idx)
					3'd0:    c = "&";
					3'd1:    c = "l";
					3'd2:    c = "t";
					default: c = ";";
				endcase
			end
			ENT_GT: begin
				case (idx)
					3'd0:    c = "&";
					3'd1:    c = "g";
					3'd2:    c = "t";
					default: c = ";";
				endcase
			end
			ENT_APOS: begin
				case (idx)
					3'd0:    c = "&";
					3'd1:    c = "a";
					3'd2:    c = "p";
					3'd3:    c = "o";
					3'd4:    c = "s";
					default: c = ";";
				endcase
			end
			ENT_QUOT: begin
				case (idx)
					3'd0:    c = "&";
					3'd1:    c = "q";
					3'd2:    c = "u";
					3'd3:    c = "o";
					3'd4:    c = "t";
					default: c = ";";
				endcase
			end
			default: c = ";";
		endcase
		return c;
	endfunction

endpackage

// File: hdl/utf8_aware_xml_escaper_unit.sv
// Top level of the UTF-8 aware XML escaper.
// Input channel: one raw byte per request (in_byte, last_byte on the final byte of a
// string); a request is taken at a clock edge with push high and full low.
// Output channel: escaped bytes, oldest first; the head is on out_byte and the flags
// while empty is low and is taken at an edge with pop high and empty low.
// Each input byte goes through the front end, which holds the bytes of a multi-byte
// character until it is complete, then into a small request queue (JOB_DEPTH entries).
// The back end turns one request into its bytes, one per cycle unless pop stalls it,
// into the result reg. A taken byte goes through the queue to the result register.
// One input byte per cycle is taken while every byte maps to one output byte and pop
// stays high. An entity becomes 4 to 6 output bytes, a completed character of n bytes
// becomes n bytes; full rises while the queue holds JOB_DEPTH pending requests.
// A byte that only extends a pending character produces nothing.
// When pop is low with a result waiting, the result register holds and the back end
// stops; the queue keeps taking input until it fills.
// Reset (arst_n low) empties the queue and result register and drops any pending
// character; there is no clearing pass.
`timescale 1ns / 1ps
module utf8_aware_xml_escaper_unit #(
	parameter int JOB_DEPTH = uxe_pkg::JOB_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic [uxe_pkg::BYTE_W-1:0] in_byte,
	input  logic                       last_byte,
	input  logic                       pop,
	output logic                       empty,
	output logic [uxe_pkg::BYTE_W-1:0] out_byte,
	output logic                       byte_valid,
	output logic                       run_last,
	output logic                       string_end,
	output logic                       truncated
);
	import uxe_pkg::*;

	job_t front_job;
	job_t head_job;
	logic front_push;
	logic q_empty;
	logic q_full;
	logic back_pop;

	assign full = q_full;

	uxe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.in_byte   (in_byte),
		.last_byte (last_byte),
		.q_full    (q_full),
		.job       (front_job),
		.job_push  (front_push)
	);

	uxe_queue #(
		.DEPTH (JOB_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (front_push),
		.din    (front_job),
		.rd     (back_pop),
		.dout   (head_job),
		.empty  (q_empty),
		.full   (q_full)
	);

	uxe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job        (head_job),
		.job_valid  (~q_empty),
		.job_pop    (back_pop),
		.pop        (pop),
		.empty      (empty),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.run_last   (run_last),
		.string_end (string_end),
		.truncated  (truncated)
	);

endmodule

// File: hdl/uxe_front.sv
// Front end: groups input bytes into characters and classifies each request.
`timescale 1ns / 1ps
module uxe_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [uxe_pkg::BYTE_W-1:0] in_byte,
	input  logic                       last_byte,
	input  logic                       q_full,
	output uxe_pkg::job_t              job,
	output logic                       job_push
);
	import uxe_pkg::*;

	logic [HELD_DEPTH-1:0][BYTE_W-1:0] held_q;
	logic [CNT_W-1:0]                  held_count_q;
	logic [CNT_W-1:0]                  char_len_q;

	logic             accept;
	logic             job_vld;
	logic             wr_en;
	logic [CNT_W-1:0] wr_idx;
	logic [CNT_W-1:0] cnt_d;
	logic [CNT_W-1:0] len_d;
	logic [CNT_W-1:0] lead;

	assign accept = push & ~q_full;

	// Classify the incoming byte against the pending character
	always_comb begin
		cnt_d       = held_count_q;
		len_d       = char_len_q;
		wr_en       = 1'b0;
		wr_idx      = held_count_q;
		job_vld     = 1'b1;
		lead        = lead_length(in_byte);
		job.kind    = JOB_BYTE;
		job.ent     = ENT_AMP;
		job.data    = in_byte;
		job.held_n  = held_count_q;
		job.held    = held_q;
		job.last    = last_byte;
		if (held_count_q == '0) begin
			if (lead == 3'd1) begin
				case (in_byte)
					CH_AMP: begin
						job.kind = JOB_ENT;
						job.ent  = ENT_AMP;
					end
					CH_LT: begin
						job.kind = JOB_ENT;
						job.ent  = ENT_LT;
					end
					CH_GT: begin
						job.kind = JOB_ENT;
						job.ent  = ENT_GT;
					end
					CH_APOS: begin
						job.kind = JOB_ENT;
						job.ent  = ENT_APOS;
					end
					CH_QUOT: begin
						job.kind = JOB_ENT;
						job.ent  = ENT_QUOT;
					end
					default: job.kind = JOB_BYTE;
				endcase
			end else begin
				wr_en   = 1'b1;
				wr_idx  = '0;
				cnt_d   = 3'd1;
				len_d   = lead;
				job_vld = 1'b0;
			end
		end else if (({1'b0, held_count_q} + 4'd1) >= {1'b0, char_len_q}) begin
			job.kind = JOB_FLUSH;
			cnt_d    = '0;
			len_d    = '0;
		end else begin
			wr_en   = 1'b1;
			cnt_d   = held_count_q + 3'd1;
			job_vld = 1'b0;
		end
		// string ends inside a character: drop it
		if (last_byte && (cnt_d != '0)) begin
			job.kind = JOB_TRUNC;
			job_vld  = 1'b1;
			cnt_d    = '0;
			len_d    = '0;
		end
	end

	assign job_push = accept & job_vld;

	// Pending-character counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count_q <= '0;
			char_len_q   <= '0;
		end else if (accept) begin
			held_count_q <= cnt_d;
			char_len_q   <= len_d;
		end
	end

	// Held bytes of the pending character
	always_ff @(posedge clk) begin
		if (accept && wr_en) begin
			held_q[wr_idx] <= in_byte;
		end
	end

	a_held_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		(held_count_q != '0) |-> ((held_count_q < char_len_q) && (char_len_q <= 3'd6)))
		else $error("pending byte count not below character length");

endmodule

// File: hdl/uxe_queue.sv
// Short request queue between the front end and the back end.
`timescale 1ns / 1ps
module uxe_queue #(
	parameter int DEPTH = uxe_pkg::JOB_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  uxe_pkg::job_t din,
	input  logic          rd,
	output uxe_pkg::job_t dout,
	output logic          empty,
	output logic          full
);
	import uxe_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W_Q = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0]   LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W_Q-1:0] FULL_CNT = CNT_W_Q'(DEPTH);

	job_t                mem_q [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [CNT_W_Q-1:0]  count_q;
	logic                do_wr;
	logic                do_rd;

	assign empty = (count_q == '0);
	assign full  = (count_q == FULL_CNT);
	assign do_wr = wr & ~full;
	assign do_rd = rd & ~empty;
	assign dout  = mem_q[rd_ptr_q];

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("request queue over its depth");

endmodule

// File: hdl/uxe_back.sv
// Back end: expands each request into output bytes and holds the result register.
`timescale 1ns / 1ps
module uxe_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  uxe_pkg::job_t              job,
	input  logic                       job_valid,
	output logic                       job_pop,
	input  logic                       pop,
	output logic                       empty,
	output logic [uxe_pkg::BYTE_W-1:0] out_byte,
	output logic                       byte_valid,
	output logic                       run_last,
	output logic                       string_end,
	output logic                       truncated
);
	import uxe_pkg::*;

	logic [CNT_W-1:0]  idx_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              byte_valid_q;
	logic              run_last_q;
	logic              string_end_q;
	logic              truncated_q;

	logic [CNT_W-1:0]  len;
	logic [BYTE_W-1:0] nxt_byte;
	logic              nxt_valid;
	logic              nxt_trunc;
	logic              nxt_last;
	logic              advance;
	logic              taken;

	// Length and current byte of the request at the head of the queue
	always_comb begin
		nxt_byte  = job.data;
		nxt_valid = 1'b1;
		nxt_trunc = 1'b0;
		case (job.kind)
			JOB_BYTE: len = 3'd1;
			JOB_ENT: begin
				len      = ent_len(job.ent);
				nxt_byte = ent_char(job.ent, idx_q);
			end
			JOB_FLUSH: begin
				len = job.held_n + 3'd1;
				if (idx_q < job.held_n) begin
					nxt_byte = job.held[idx_q];
				end
			end
			JOB_TRUNC: begin
				len       = 3'd1;
				nxt_byte  = '0;
				nxt_valid = 1'b0;
				nxt_trunc = 1'b1;
			end
			default: len = 3'd1;
		endcase
		nxt_last = (idx_q == (len - 3'd1));
	end

	assign taken   = out_valid_q & pop;
	assign advance = job_valid & (~out_valid_q | pop);
	assign job_pop = advance & nxt_last;

	// Byte index within the current request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				idx_q <= nxt_last ? '0 : idx_q + 3'd1;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (taken) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (advance) begin
			out_byte_q   <= nxt_byte;
			byte_valid_q <= nxt_valid;
			run_last_q   <= nxt_last;
			string_end_q <= nxt_last & job.last;
			truncated_q  <= nxt_trunc;
		end
	end

	assign empty      = ~out_valid_q;
	assign out_byte   = out_byte_q;
	assign byte_valid = byte_valid_q;
	assign run_last   = run_last_q;
	assign string_end = string_end_q;
	assign truncated  = truncated_q;

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid |-> (idx_q < len))
		else $error("byte index past request length");

	a_end_is_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && string_end_q) |-> run_last_q)
		else $error("string end without run end");

	a_trunc_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && truncated_q) |-> (!byte_valid_q && run_last_q && string_end_q))
		else $error("truncation result malformed");

endmodule
